### hdl/cgv_pkg.sv
// ----------------------------------------------------------------------------
// cgv_pkg
// Shared widths, constants and pipeline sideband types for the softened
// central-gravity position-Verlet step.
// ----------------------------------------------------------------------------
package cgv_pkg;

  // position format, signed q16.16
  localparam int POS_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int MU_W      = 32;

  // squared radius and its root
  localparam int R2_W   = 2 * POS_W;
  localparam int ROOT_W = R2_W / 2;

  // 2*cur - old needs two more bits
  localparam int BASE_W = POS_W + 2;

  // 1/dt^2 and the first divider (mu*dt^2 / r^2)
  localparam int             INV_W   = 14;
  localparam logic [INV_W-1:0] DT2_INV = 14'd10000;
  localparam int DEN1_W = R2_W + INV_W;
  localparam int T_W    = 39;
  localparam int T_LO_W = 32;
  localparam int T_HI_W = T_W - T_LO_W;
  localparam int NUM1_SH = 2 * FRAC_BITS + 16;
  localparam int MU_SH   = NUM1_SH - T_W;

  // per-axis divider: (t*|c| + d*2^15) / (d*2^16)
  localparam int ROUND_SH = 16;
  localparam int DEN2_W   = ROOT_W + ROUND_SH;
  localparam int AX_Q_W   = 24;
  localparam int NUM2_W   = DEN2_W + AX_Q_W;

  // softening floor 0.0625 with 2F fractional bits
  localparam logic [R2_W-1:0] R2_FLOOR = R2_W'(1) << (2 * FRAC_BITS - 4);

  localparam logic [MU_W-1:0] MU_RESET = 32'd65536;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic        [POS_W-1:0]  mag_t;
  typedef logic signed [BASE_W-1:0] base_t;

  // per-axis data carried alongside the arithmetic
  typedef struct packed {
    pos_t  cur;
    mag_t  mag;
    base_t base;
  } axis_t;

  // sideband through the square root
  typedef struct packed {
    axis_t [2:0]       ax;
    logic [MU_W-1:0]   mu;
    logic [R2_W-1:0]   r2c;
  } sq_side_t;

  // sideband through the t divider
  typedef struct packed {
    axis_t [2:0]       ax;
    logic [ROOT_W-1:0] root;
  } td_side_t;

  // sideband through an axis divider
  typedef struct packed {
    pos_t  cur;
    base_t base;
  } ax_side_t;

endpackage

### hdl/cgv_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// cgv_isqrt_pipe
// Pipelined integer square root, one root bit per register stage, with a
// valid bit and a sideband word travelling alongside.
// ----------------------------------------------------------------------------
module cgv_isqrt_pipe #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RT_W  = IN_W / 2;
  localparam int REM_W = RT_W + 2;

  logic [IN_W-1:0]   rad_r  [RT_W];
  logic [REM_W-1:0]  rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [SIDE_W-1:0] side_r [RT_W];
  logic              vld_r  [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stg
    logic [IN_W-1:0]   p_rad;
    logic [REM_W-1:0]  p_rem;
    logic [RT_W-1:0]   p_root;
    logic [SIDE_W-1:0] p_side;
    logic              p_vld;
    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // stage input: ports for the first stage, previous register otherwise
    if (s == 0) begin : g_first
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rad  = rad_r[s-1];
      assign p_rem  = rem_r[s-1];
      assign p_root = root_r[s-1];
      assign p_side = side_r[s-1];
      assign p_vld  = vld_r[s-1];
    end

    // bring down two radicand bits and try the next root bit
    assign shifted = {p_rem[REM_W-3:0], p_rad[IN_W-1 -: 2]};
    assign trial   = {p_root, 2'b01};
    assign fits    = (shifted >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[s]  <= p_rad << 2;
      rem_r[s]  <= fits ? (shifted - trial) : shifted;
      root_r[s] <= {p_root[RT_W-2:0], fits};
      side_r[s] <= p_side;
    end
  end

  assign out_valid = vld_r[RT_W-1];
  assign out_root  = root_r[RT_W-1];
  assign out_side  = side_r[RT_W-1];

endmodule

### hdl/cgv_div_pipe.sv
// ----------------------------------------------------------------------------
// cgv_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. The
// caller splits the dividend into a starting remainder below the divisor
// and the low bits still to be brought down.
// ----------------------------------------------------------------------------
module cgv_div_pipe #(
  parameter int DEN_W  = 48,
  parameter int Q_W    = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [Q_W-1:0]    in_low,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    low_r  [Q_W];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [Q_W-1:0]    quo_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic              vld_r  [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stg
    logic [DEN_W-1:0]  p_rem;
    logic [Q_W-1:0]    p_low;
    logic [DEN_W-1:0]  p_den;
    logic [Q_W-1:0]    p_quo;
    logic [SIDE_W-1:0] p_side;
    logic              p_vld;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // stage input: ports for the first stage, previous register otherwise
    if (s == 0) begin : g_first
      assign p_rem  = in_rem;
      assign p_low  = in_low;
      assign p_den  = in_den;
      assign p_quo  = '0;
      assign p_side = in_side;
      assign p_vld  = in_valid;
    end else begin : g_next
      assign p_rem  = rem_r[s-1];
      assign p_low  = low_r[s-1];
      assign p_den  = den_r[s-1];
      assign p_quo  = quo_r[s-1];
      assign p_side = side_r[s-1];
      assign p_vld  = vld_r[s-1];
    end

    // bring down one dividend bit, subtract when the divisor fits
    assign trial = {p_rem, p_low[Q_W-1]};
    assign diff  = trial - {1'b0, p_den};
    assign fits  = (trial >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r[s]  <= p_low << 1;
      den_r[s]  <= p_den;
      quo_r[s]  <= {p_quo[Q_W-2:0], fits};
      side_r[s] <= p_side;
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

### hdl/central_gravity_verlet_step_top.sv
// ----------------------------------------------------------------------------
// central_gravity_verlet_step_top
// One position-Verlet step of a particle under softened central gravity,
// next = 2*cur - old - mu*dt^2*r/max(|r|,0.25)^3, dt = 0.01, q16.16.
//
//   channel  | ports                          | handshake
//   ---------+--------------------------------+------------------------------
//   request  | in_cur_*, in_old_*             | start high while busy low
//   result   | out_next_*, out_back_*         | out_valid strobe, one cycle
//   config   | cfg_wdata (gravity_mu)         | cfg_we, written at once
//
// A request is taken every cycle out of reset; busy is high only while
// rst_n is low. Each result passes through 32 square-root stages, 39
// stages for the mu*dt^2/r^2 divider and 24 stages for the per-axis
// rounding divider, plus seven stages of multiply, add and saturation.
// Synchronous reset clears the valid bits and restores gravity_mu to 1.0.
// The receiver cannot stall, so results leave the pipeline unconditionally.
// ----------------------------------------------------------------------------
module central_gravity_verlet_step_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cgv_pkg::pos_t      in_cur_x,
  input  cgv_pkg::pos_t      in_cur_y,
  input  cgv_pkg::pos_t      in_cur_z,
  input  cgv_pkg::pos_t      in_old_x,
  input  cgv_pkg::pos_t      in_old_y,
  input  cgv_pkg::pos_t      in_old_z,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output cgv_pkg::pos_t      out_next_x,
  output cgv_pkg::pos_t      out_next_y,
  output cgv_pkg::pos_t      out_next_z,
  output cgv_pkg::pos_t      out_back_x,
  output cgv_pkg::pos_t      out_back_y,
  output cgv_pkg::pos_t      out_back_z
);

  localparam int POS_W  = cgv_pkg::POS_W;
  localparam int BASE_W = cgv_pkg::BASE_W;
  localparam int LAT    = 3 + cgv_pkg::ROOT_W + 1 + cgv_pkg::T_W + 2 + cgv_pkg::AX_Q_W + 1;

  localparam logic signed [BASE_W:0] SAT_MAX =
    {{(BASE_W - POS_W + 2){1'b0}}, {(POS_W - 1){1'b1}}};
  localparam logic signed [BASE_W:0] SAT_MIN =
    {{(BASE_W - POS_W + 1){1'b1}}, 1'b1, {(POS_W - 1){1'b0}}};

  logic accept;

  // configuration register
  logic [cgv_pkg::MU_W-1:0] mu_r;

  // stage 1: captured request
  cgv_pkg::pos_t            cur1_r [3];
  cgv_pkg::pos_t            old1_r [3];
  logic [cgv_pkg::MU_W-1:0] mu1_r;
  logic                     vld1_r;

  // stage 2: magnitudes, squares, 2*cur - old
  cgv_pkg::axis_t           ax2_nxt [3];
  logic [cgv_pkg::R2_W-1:0] sq2_nxt [3];
  cgv_pkg::axis_t           ax2_r   [3];
  logic [cgv_pkg::R2_W-1:0] sq2_r   [3];
  logic [cgv_pkg::MU_W-1:0] mu2_r;
  logic                     vld2_r;

  // stage 3: softened squared radius
  logic [cgv_pkg::R2_W-1:0] r2_sum;
  cgv_pkg::sq_side_t        sq3_r;
  logic                     vld3_r;

  // square root
  logic                       sq_vld;
  logic [cgv_pkg::ROOT_W-1:0] sq_root;
  cgv_pkg::sq_side_t          sq_side;

  // stage 4: divider operands for t
  logic [cgv_pkg::DEN1_W-1:0] den4_r;
  logic [cgv_pkg::DEN1_W-1:0] rem4_r;
  cgv_pkg::td_side_t          td4_r;
  logic                       vld4_r;

  // t divider
  logic                    td_vld;
  logic [cgv_pkg::T_W-1:0] td_quo;
  cgv_pkg::td_side_t       td_side;

  // stage 5: partial products t*|c|
  logic [cgv_pkg::T_LO_W+POS_W-1:0] plo5_r [3];
  logic [cgv_pkg::T_HI_W+POS_W-1:0] phi5_r [3];
  cgv_pkg::ax_side_t                axs5_r [3];
  logic [cgv_pkg::ROOT_W-1:0]       root5_r;
  logic                             vld5_r;

  // stage 6: rounded dividend per axis
  logic [cgv_pkg::NUM2_W-1:0] num6_nxt [3];
  logic [cgv_pkg::NUM2_W-1:0] num6_r   [3];
  logic [cgv_pkg::DEN2_W-1:0] den6_r;
  cgv_pkg::ax_side_t          axs6_r   [3];
  logic                       vld6_r;

  // axis dividers
  logic                       ax_vld  [3];
  logic [cgv_pkg::AX_Q_W-1:0] ax_quo  [3];
  cgv_pkg::ax_side_t          ax_side [3];

  // stage 7: output registers
  logic signed [BASE_W:0] nx7_sum [3];
  cgv_pkg::pos_t          nx7_nxt [3];
  cgv_pkg::pos_t          nx7_r   [3];
  cgv_pkg::pos_t          bk7_r   [3];
  logic                   vld7_r;

  // the pipeline takes a request every cycle outside reset
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // gravity_mu register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= cgv_pkg::MU_RESET;
    end else if (cfg_we) begin
      mu_r <= cfg_wdata;
    end
  end

  // stage 1: request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur1_r[0] <= in_cur_x;
      cur1_r[1] <= in_cur_y;
      cur1_r[2] <= in_cur_z;
      old1_r[0] <= in_old_x;
      old1_r[1] <= in_old_y;
      old1_r[2] <= in_old_z;
      mu1_r     <= mu_r;
    end
  end

  // stage 2: magnitude, square and 2*cur - old per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax2_nxt[i].cur  = cur1_r[i];
      ax2_nxt[i].mag  = cur1_r[i][POS_W-1] ? (~cur1_r[i] + 1'b1) : cur1_r[i];
      ax2_nxt[i].base = (BASE_W'(cur1_r[i]) <<< 1) - BASE_W'(old1_r[i]);
      sq2_nxt[i]      = cgv_pkg::R2_W'(ax2_nxt[i].mag) * cgv_pkg::R2_W'(ax2_nxt[i].mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ax2_r[i] <= ax2_nxt[i];
      sq2_r[i] <= sq2_nxt[i];
    end
    mu2_r <= mu1_r;
  end

  // stage 3: sum of squares with the softening floor
  assign r2_sum = sq2_r[0] + sq2_r[1] + sq2_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    sq3_r.ax[0] <= ax2_r[0];
    sq3_r.ax[1] <= ax2_r[1];
    sq3_r.ax[2] <= ax2_r[2];
    sq3_r.mu    <= mu2_r;
    sq3_r.r2c   <= (r2_sum < cgv_pkg::R2_FLOOR) ? cgv_pkg::R2_FLOOR : r2_sum;
  end

  // d = floor(sqrt(r2c))
  cgv_isqrt_pipe #(
    .IN_W   (cgv_pkg::R2_W),
    .SIDE_W ($bits(cgv_pkg::sq_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld3_r),
    .in_rad    (sq3_r.r2c),
    .in_side   (sq3_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // stage 4: 10000*r2c and the leading part of mu*2^48
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    den4_r     <= cgv_pkg::DEN1_W'(sq_side.r2c) * cgv_pkg::DEN1_W'(cgv_pkg::DT2_INV);
    rem4_r     <= cgv_pkg::DEN1_W'(sq_side.mu) << cgv_pkg::MU_SH;
    td4_r.ax   <= sq_side.ax;
    td4_r.root <= sq_root;
  end

  // t = mu*2^48 / (10000*r2c); the low dividend bits are all zero
  cgv_div_pipe #(
    .DEN_W  (cgv_pkg::DEN1_W),
    .Q_W    (cgv_pkg::T_W),
    .SIDE_W ($bits(cgv_pkg::td_side_t))
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld4_r),
    .in_rem    (rem4_r),
    .in_low    ({cgv_pkg::T_W{1'b0}}),
    .in_den    (den4_r),
    .in_side   (td4_r),
    .out_valid (td_vld),
    .out_quo   (td_quo),
    .out_side  (td_side)
  );

  // stage 5: t*|c| as two partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= td_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      plo5_r[i] <= (cgv_pkg::T_LO_W + POS_W)'(td_quo[cgv_pkg::T_LO_W-1:0]) *
                   (cgv_pkg::T_LO_W + POS_W)'(td_side.ax[i].mag);
      phi5_r[i] <= (cgv_pkg::T_HI_W + POS_W)'(td_quo[cgv_pkg::T_W-1:cgv_pkg::T_LO_W]) *
                   (cgv_pkg::T_HI_W + POS_W)'(td_side.ax[i].mag);
      axs5_r[i].cur  <= td_side.ax[i].cur;
      axs5_r[i].base <= td_side.ax[i].base;
    end
    root5_r <= td_side.root;
  end

  // stage 6: t*|c| + d*2^15, divisor d*2^16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num6_nxt[i] = (cgv_pkg::NUM2_W'(phi5_r[i]) << cgv_pkg::T_LO_W)
                  + cgv_pkg::NUM2_W'(plo5_r[i])
                  + (cgv_pkg::NUM2_W'(root5_r) << (cgv_pkg::ROUND_SH - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else begin
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num6_r[i] <= num6_nxt[i];
      axs6_r[i] <= axs5_r[i];
    end
    den6_r <= cgv_pkg::DEN2_W'(root5_r) << cgv_pkg::ROUND_SH;
  end

  // rounded per-axis pull magnitude
  for (genvar i = 0; i < 3; i++) begin : g_axdiv
    cgv_div_pipe #(
      .DEN_W  (cgv_pkg::DEN2_W),
      .Q_W    (cgv_pkg::AX_Q_W),
      .SIDE_W ($bits(cgv_pkg::ax_side_t))
    ) u_axdiv (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld6_r),
      .in_rem    (num6_r[i][cgv_pkg::NUM2_W-1:cgv_pkg::AX_Q_W]),
      .in_low    (num6_r[i][cgv_pkg::AX_Q_W-1:0]),
      .in_den    (den6_r),
      .in_side   (axs6_r[i]),
      .out_valid (ax_vld[i]),
      .out_quo   (ax_quo[i]),
      .out_side  (ax_side[i])
    );
  end

  // stage 7: pull toward the origin and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ax_side[i].cur[POS_W-1]) begin
        nx7_sum[i] = (BASE_W + 1)'(ax_side[i].base) + $signed({1'b0, ax_quo[i]});
      end else begin
        nx7_sum[i] = (BASE_W + 1)'(ax_side[i].base) - $signed({1'b0, ax_quo[i]});
      end
      if (nx7_sum[i] > SAT_MAX) begin
        nx7_nxt[i] = SAT_MAX[POS_W-1:0];
      end else if (nx7_sum[i] < SAT_MIN) begin
        nx7_nxt[i] = SAT_MIN[POS_W-1:0];
      end else begin
        nx7_nxt[i] = nx7_sum[i][POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
    end else begin
      vld7_r <= ax_vld[0] && ax_vld[1] && ax_vld[2];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nx7_r[i] <= nx7_nxt[i];
      bk7_r[i] <= ax_side[i].cur;
    end
  end

  assign out_valid  = vld7_r;
  assign out_next_x = nx7_r[0];
  assign out_next_y = nx7_r[1];
  assign out_next_z = nx7_r[2];
  assign out_back_x = bk7_r[0];
  assign out_back_y = bk7_r[1];
  assign out_back_z = bk7_r[2];

  // every accepted request yields a result after the fixed latency
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("request did not produce a result at the pipeline latency");

  // no result without a request at the pipeline latency
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

  // the returned previous position matches the request's current position in x and z
  a_back_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_back_x == $past(in_cur_x, LAT)) &&
                  (out_back_z == $past(in_cur_z, LAT)))
    else $error("returned previous position does not match the request");

endmodule
